// ----- rtl/maf_pkg.sv -----
// Shared constants for the moving average filter.
package maf_pkg;

    // Width of the window length register and of the divisor.
    localparam int LEN_W = 7;

endpackage

// ----- rtl/maf_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/maf_div.sv -----
// Serial signed divider: window sum by window length, one quotient bit per cycle.
module maf_div
    import maf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    localparam int SUM_W = SAMPLE_BITS + LEN_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_W-1:0]       i_sum,
    input  logic [LEN_W-1:0]              i_len,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_quot
);

    localparam int CW = $clog2(SAMPLE_BITS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic                   r_neg, n_neg;
    logic [LEN_W-1:0]       r_rem, n_rem;
    logic [SAMPLE_BITS-1:0] r_dvd, n_dvd;
    logic [CW-1:0]          r_cnt, n_cnt;

    logic [SUM_W-1:0]       mag;
    logic [LEN_W+1:0]       trial;
    logic                   borrow;

    // Magnitude of the dividend; the quotient always fits in SAMPLE_BITS bits,
    // so the upper part is already below the divisor and seeds the remainder
    assign mag = i_sum[SUM_W-1] ? (~$unsigned(i_sum) + SUM_W'(1)) : $unsigned(i_sum);

    // Trial subtract of the divisor from the shifted remainder
    assign trial  = {1'b0, r_rem, r_dvd[SAMPLE_BITS-1]} - {2'b00, i_len};
    assign borrow = trial[LEN_W+1];

    // Next-state logic
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_sum[SUM_W-1];
            n_rem  = mag[SUM_W-1:SAMPLE_BITS];
            n_dvd  = mag[SAMPLE_BITS-1:0];
            n_cnt  = CW'(SAMPLE_BITS - 1);
        end else if (r_busy) begin
            if (borrow) begin
                n_rem = {r_rem[LEN_W-2:0], r_dvd[SAMPLE_BITS-1]};
            end else begin
                n_rem = trial[LEN_W-1:0];
            end
            n_dvd = {r_dvd[SAMPLE_BITS-2:0], ~borrow};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_cnt <= n_cnt;
    end

    // Restore the sign: truncation toward zero
    assign o_quot = r_neg ? $signed(~r_dvd + SAMPLE_BITS'(1)) : $signed(r_dvd);
    assign o_done = r_done;

endmodule

// ----- rtl/moving_average_filter_unit.sv -----
// Boxcar moving average filter: window store, running sum and serial divide.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_sample) takes one signed
//   sample per word. Output channel (o_out_valid / i_out_stall / o_average)
//   returns one word per sample: the mean of the newest window_length
//   samples, truncated toward zero. Window length is written on the
//   configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) while
//   the block is idle; a pending write holds off the input for that cycle.
//   0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW.
//   A new sample is accepted only once the previous result has reached the
//   output register; the divider produces one quotient bit per cycle. The
//   running sum is updated with one RAM read and one write. The first sample
//   after a length write rebuilds the sum by reading the window from the RAM.
//   Reset (synchronous) empties the window: entries older than the samples
//   received since reset read as zero through a fill count, no clearing pass.
//   A finished word waits in the output register while the receiver stalls;
//   the next sample is accepted meanwhile and its result waits until the
//   output register frees.
module moving_average_filter_unit
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // average output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    // window length register
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [LEN_W-1:0]              i_cfg_data
);

    localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int DW     = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam int SUM_W  = SAMPLE_BITS + LEN_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_FILLW = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SDRN  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                    r_state, n_state;
    logic [AW-1:0]                 r_wp, n_wp;
    logic [FILL_W-1:0]             r_fill, n_fill;
    logic [LEN_W-1:0]              r_len, n_len;
    logic                          r_dirty, n_dirty;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic signed [SAMPLE_BITS-1:0] r_new, n_new;
    logic                          r_old_vld, n_old_vld;
    logic                          r_take, n_take;
    logic [LEN_W-1:0]              r_k, n_k;
    logic [AW-1:0]                 r_scan_addr, n_scan_addr;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_average, n_average;

    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [DW-1:0]          old_diff;
    logic [AW-1:0]          old_addr;
    logic [AW-1:0]          wp_inc, scan_dec;
    logic [FILL_W-1:0]      fill_inc;
    logic [LEN_W-1:0]       cfg_len;
    logic signed [SUM_W-1:0] new_ext, rd_ext;
    logic                   in_acc, out_free;
    logic                   div_start, div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;

    // Window store
    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_new),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Serial divider
    maf_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_sum),
        .i_len   (r_len),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Address of the sample that leaves the window: write pointer minus length
    assign old_diff = DW'(r_wp) - DW'(r_len);
    always_comb begin
        if (old_diff[DW-1]) begin
            old_addr = AW'(old_diff + DW'(MAX_WINDOW));
        end else begin
            old_addr = old_diff[AW-1:0];
        end
    end

    // Circular pointer steps and saturating fill count
    assign wp_inc   = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + AW'(1);
    assign scan_dec = (r_scan_addr == '0) ? AW'(MAX_WINDOW - 1) : r_scan_addr - AW'(1);
    assign fill_inc = (r_fill == FILL_W'(MAX_WINDOW)) ? r_fill : r_fill + FILL_W'(1);

    // Clamp the written length into 1..MAX_WINDOW
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_len = LEN_W'(1);
        end else if (int'(i_cfg_data) > MAX_WINDOW) begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end else begin
            cfg_len = i_cfg_data;
        end
    end

    // Sign-extend samples to the sum width
    assign new_ext = {{LEN_W{r_new[SAMPLE_BITS-1]}}, r_new};
    assign rd_ext  = {{LEN_W{rd_data[SAMPLE_BITS-1]}}, rd_data};

    // A length write takes the idle cycle ahead of a sample
    assign in_acc   = i_in_valid && (r_state == S_IDLE) && !i_cfg_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_wp          = r_wp;
        n_fill        = r_fill;
        n_len         = r_len;
        n_dirty       = r_dirty;
        n_sum         = r_sum;
        n_new         = r_new;
        n_old_vld     = r_old_vld;
        n_take        = 1'b0;
        n_k           = r_k;
        n_scan_addr   = r_scan_addr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_average     = r_average;
        wr_en         = 1'b0;
        wr_addr       = r_wp;
        rd_en         = 1'b0;
        rd_addr       = old_addr;
        div_start     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // take a length write; it forces a rebuild of the sum
                if (i_cfg_valid) begin
                    n_len   = cfg_len;
                    n_dirty = 1'b1;
                end
                // accept a word and fetch the sample that leaves the window
                if (in_acc) begin
                    n_new     = i_sample;
                    rd_en     = 1'b1;
                    n_old_vld = CNT_W'(r_fill) >= CNT_W'(r_len);
                    n_state   = r_dirty ? S_FILLW : S_UPD;
                end
            end
            S_UPD: begin
                // store the new sample and adjust the running sum
                wr_en  = 1'b1;
                n_wp   = wp_inc;
                n_fill = fill_inc;
                n_sum  = r_sum + new_ext - (r_old_vld ? rd_ext : SUM_W'(0));
                n_state = S_DIV;
            end
            S_FILLW: begin
                // store the new sample and start a fresh sum from it backward
                wr_en       = 1'b1;
                n_wp        = wp_inc;
                n_fill      = fill_inc;
                n_sum       = '0;
                n_k         = '0;
                n_scan_addr = r_wp;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                // read one window entry per cycle, newest first
                rd_en       = 1'b1;
                rd_addr     = r_scan_addr;
                n_take      = CNT_W'(r_k) < CNT_W'(r_fill);
                n_k         = r_k + LEN_W'(1);
                n_scan_addr = scan_dec;
                if (r_take) begin
                    n_sum = r_sum + rd_ext;
                end
                if (r_k == r_len - LEN_W'(1)) begin
                    n_state = S_SDRN;
                end
            end
            S_SDRN: begin
                // add the last entry in flight
                if (r_take) begin
                    n_sum = r_sum + rd_ext;
                end
                n_dirty = 1'b0;
                n_state = S_DIV;
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold the quotient until the output register frees
                if (out_free) begin
                    n_average   = div_quot;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_len       <= LEN_W'(1);
            r_dirty     <= 1'b0;
            r_sum       <= '0;
            r_take      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_dirty     <= n_dirty;
            r_sum       <= n_sum;
            r_take      <= n_take;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_new       <= n_new;
        r_old_vld   <= n_old_vld;
        r_scan_addr <= n_scan_addr;
        r_average   <= n_average;
    end

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule
